// ===== rtl/core/snfs_pkg.sv =====
// Package for the SPI NOR flash sequencer: opcodes, result kinds, flash
// command bytes, geometry constants and the item structs. No dependencies.
`default_nettype none
package snfs_pkg;

  localparam int unsigned PAGE_BYTES   = 256;
  localparam int unsigned SECTOR_BYTES = 4096;
  localparam int unsigned PAGE_BITS    = $clog2(PAGE_BYTES);
  localparam int unsigned SECTOR_BITS  = $clog2(SECTOR_BYTES);
  localparam int unsigned ROOM_W       = PAGE_BITS + 1;
  localparam int unsigned SECT_W       = 24 - SECTOR_BITS;

  typedef enum logic [2:0] {
    OP_READ   = 3'd0,
    OP_WRITE  = 3'd1,
    OP_ERASE  = 3'd2,
    OP_CHIP   = 3'd3,
    OP_ID     = 3'd4,
    OP_WBYTE  = 3'd5,
    OP_REPLY  = 3'd6,
    OP_NONE   = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    KIND_SPI  = 2'd0,
    KIND_READ = 2'd1,
    KIND_ID   = 2'd2,
    KIND_DONE = 2'd3
  } kind_t;

  localparam logic [7:0] CMD_WREN  = 8'h06;
  localparam logic [7:0] CMD_RDSR  = 8'h05;
  localparam logic [7:0] CMD_READ  = 8'h03;
  localparam logic [7:0] CMD_PP    = 8'h02;
  localparam logic [7:0] CMD_SE    = 8'h20;
  localparam logic [7:0] CMD_CE    = 8'hC7;
  localparam logic [7:0] CMD_RDID  = 8'h90;
  localparam logic [7:0] BYTE_DUMMY = 8'hFF;

  typedef struct packed {
    logic [2:0]  op;
    logic [1:0]  flash_port;
    logic [23:0] start_address;
    logic [23:0] byte_count;
    logic [7:0]  data_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  mosi_byte;
    logic        end_frame;
    logic [1:0]  port_out;
    logic [7:0]  read_data;
    logic [15:0] id_value;
    logic        last;
  } out_item_t;

  // Up to three results caused by one input item.
  typedef struct packed {
    logic [1:0] count;
    out_item_t  r0;
    out_item_t  r1;
    out_item_t  r2;
  } res_group_t;

endpackage
`default_nettype wire

// ===== rtl/core/snfs_if.sv =====
// Valid/ready channel interface carrying one payload item.
// Depends on snfs_pkg for the payload types.
`default_nettype none
interface snfs_in_if;
  logic                  valid;
  logic                  ready;
  snfs_pkg::in_item_t    payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface snfs_out_if;
  logic                  valid;
  logic                  ready;
  snfs_pkg::out_item_t   payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/snfs_front.sv =====
// Front part: accepts input items, runs the command sequencer state and
// produces a group of up to three results per item. Depends on snfs_pkg.
`default_nettype none
module snfs_front (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire snfs_pkg::in_item_t   in_item,
  output logic                      grp_valid,
  input  wire logic                 grp_ready,
  output snfs_pkg::res_group_t      grp
);
  import snfs_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE, PH_WEN, PH_CMD, PH_ADDR, PH_RDATA, PH_WWAIT, PH_WDATA,
    PH_SRCMD, PH_SRDATA, PH_CHIP, PH_IDHI, PH_IDLO
  } phase_t;

  phase_t        phase, phase_next;
  logic [2:0]    active_command, active_command_next;
  logic [23:0]   cursor_address, cursor_address_next;
  logic [23:0]   bytes_left, bytes_left_next;
  logic [ROOM_W-1:0] page_room, page_room_next;
  logic [1:0]    frame_index, frame_index_next;
  logic [SECT_W-1:0] sectors_left, sectors_left_next;
  logic [15:0]   id_accumulator, id_accumulator_next;
  logic [1:0]    port_held, port_held_next;
  res_group_t    g;

  logic          fire;
  logic [23:0]   room_full;
  logic [SECT_W-1:0] sect_dec;
  logic [23:0]   bl_dec;
  logic [ROOM_W-1:0] pr_dec;
  logic [7:0]    addr_byte;
  logic          addr_end;

  assign in_ready = !grp_valid || grp_ready;
  assign fire     = in_valid && in_ready;

  // Append one result to the group being built.
  function automatic res_group_t put(res_group_t gi, logic [1:0] kind, logic [7:0] mosi,
                                     logic endf, logic [1:0] port, logic [7:0] rd,
                                     logic [15:0] id);
    out_item_t r;
    res_group_t go;
    r.kind = kind; r.mosi_byte = mosi; r.end_frame = endf; r.port_out = port;
    r.read_data = rd; r.id_value = id; r.last = 1'b0;
    go = gi;
    unique case (gi.count)
      2'd0:    go.r0 = r;
      2'd1:    go.r1 = r;
      default: go.r2 = r;
    endcase
    go.count = gi.count + 2'd1;
    return go;
  endfunction

  // Next-state and result generation for one accepted item.
  always_comb begin
    phase_next = phase;
    active_command_next = active_command;
    cursor_address_next = cursor_address;
    bytes_left_next = bytes_left;
    page_room_next = page_room;
    frame_index_next = frame_index;
    sectors_left_next = sectors_left;
    id_accumulator_next = id_accumulator;
    port_held_next = port_held;
    g = '0;
    room_full = 24'(PAGE_BYTES) - {{(24-PAGE_BITS){1'b0}}, in_item.start_address[PAGE_BITS-1:0]};
    bl_dec = (bytes_left != 24'd0) ? bytes_left - 24'd1 : 24'd0;
    pr_dec = (page_room != '0) ? page_room - ROOM_W'(1) : '0;
    sect_dec = (sectors_left != '0) ? sectors_left - SECT_W'(1) : '0;
    addr_byte = 8'd0;
    addr_end = 1'b0;
    if (phase == PH_IDLE) begin
      if (in_item.op <= OP_ID) begin
        port_held_next = in_item.flash_port;
        active_command_next = in_item.op;
        frame_index_next = 2'd0;
        unique case (in_item.op)
          OP_READ: begin
            cursor_address_next = in_item.start_address;
            bytes_left_next = in_item.byte_count;
            g = put(g, KIND_SPI, CMD_READ, 1'b0, in_item.flash_port, 8'd0, 16'd0);
            phase_next = PH_CMD;
          end
          OP_WRITE: begin
            cursor_address_next = in_item.start_address;
            bytes_left_next = in_item.byte_count;
            if (in_item.byte_count == 24'd0) begin
              g = put(g, KIND_DONE, 8'd0, 1'b0, in_item.flash_port, 8'd0, 16'd0);
              phase_next = PH_IDLE;
            end else begin
              page_room_next = (room_full < in_item.byte_count) ? ROOM_W'(room_full)
                                                                 : ROOM_W'(in_item.byte_count);
              g = put(g, KIND_SPI, CMD_WREN, 1'b1, in_item.flash_port, 8'd0, 16'd0);
              phase_next = PH_WEN;
            end
          end
          OP_ERASE: begin
            sectors_left_next = in_item.byte_count[23:SECTOR_BITS];
            cursor_address_next = {in_item.start_address[23:SECTOR_BITS],
                                   {SECTOR_BITS{1'b0}}};
            if (in_item.byte_count[23:SECTOR_BITS] == '0) begin
              g = put(g, KIND_DONE, 8'd0, 1'b0, in_item.flash_port, 8'd0, 16'd0);
              phase_next = PH_IDLE;
            end else begin
              g = put(g, KIND_SPI, CMD_WREN, 1'b1, in_item.flash_port, 8'd0, 16'd0);
              phase_next = PH_WEN;
            end
          end
          OP_CHIP: begin
            g = put(g, KIND_SPI, CMD_WREN, 1'b1, in_item.flash_port, 8'd0, 16'd0);
            phase_next = PH_WEN;
          end
          default: begin
            cursor_address_next = 24'd0;
            id_accumulator_next = 16'd0;
            g = put(g, KIND_SPI, CMD_RDID, 1'b0, in_item.flash_port, 8'd0, 16'd0);
            phase_next = PH_CMD;
          end
        endcase
      end
    end else if (in_item.op == OP_WBYTE) begin
      if (phase == PH_WWAIT) begin
        g = put(g, KIND_SPI, in_item.data_byte, page_room == ROOM_W'(1), port_held,
                8'd0, 16'd0);
        phase_next = PH_WDATA;
      end
    end else if (in_item.op == OP_REPLY && phase != PH_WWAIT) begin
      priority case (phase)
        PH_WEN: begin
          if (active_command == OP_WRITE) begin
            g = put(g, KIND_SPI, CMD_PP, 1'b0, port_held, 8'd0, 16'd0);
            phase_next = PH_CMD;
          end else begin
            frame_index_next = 2'd0;
            g = put(g, KIND_SPI, CMD_RDSR, 1'b0, port_held, 8'd0, 16'd0);
            phase_next = PH_SRCMD;
          end
        end
        PH_CMD, PH_ADDR: begin
          if (phase == PH_ADDR && frame_index == 2'd2) begin
            // All three address bytes sent.
            priority case (active_command)
              OP_READ: begin
                if (bytes_left != 24'd0) begin
                  g = put(g, KIND_SPI, BYTE_DUMMY, bytes_left == 24'd1, port_held,
                          8'd0, 16'd0);
                  phase_next = PH_RDATA;
                end else begin
                  g = put(g, KIND_DONE, 8'd0, 1'b0, port_held, 8'd0, 16'd0);
                  phase_next = PH_IDLE;
                end
              end
              OP_WRITE: phase_next = PH_WWAIT;
              OP_ERASE: begin
                frame_index_next = 2'd1;
                g = put(g, KIND_SPI, CMD_RDSR, 1'b0, port_held, 8'd0, 16'd0);
                phase_next = PH_SRCMD;
              end
              default: begin
                g = put(g, KIND_SPI, BYTE_DUMMY, 1'b0, port_held, 8'd0, 16'd0);
                phase_next = PH_IDHI;
              end
            endcase
          end else begin
            frame_index_next = (phase == PH_CMD) ? 2'd0 : frame_index + 2'd1;
            priority case (frame_index_next)
              2'd0:    addr_byte = cursor_address[23:16];
              2'd1:    addr_byte = cursor_address[15:8];
              default: addr_byte = cursor_address[7:0];
            endcase
            addr_end = (frame_index_next == 2'd2) &&
                       (active_command == OP_ERASE ||
                        (active_command == OP_READ && bytes_left == 24'd0));
            g = put(g, KIND_SPI, addr_byte, addr_end, port_held, 8'd0, 16'd0);
            phase_next = PH_ADDR;
          end
        end
        PH_RDATA: begin
          g = put(g, KIND_READ, 8'd0, 1'b0, port_held, in_item.data_byte, 16'd0);
          bytes_left_next = bl_dec;
          if (bl_dec != 24'd0) begin
            g = put(g, KIND_SPI, BYTE_DUMMY, bl_dec == 24'd1, port_held, 8'd0, 16'd0);
            phase_next = PH_RDATA;
          end else begin
            g = put(g, KIND_DONE, 8'd0, 1'b0, port_held, 8'd0, 16'd0);
            phase_next = PH_IDLE;
          end
        end
        PH_WDATA: begin
          page_room_next = pr_dec;
          bytes_left_next = bl_dec;
          cursor_address_next = cursor_address + 24'd1;
          if (pr_dec != '0) begin
            phase_next = PH_WWAIT;
          end else begin
            frame_index_next = 2'd1;
            g = put(g, KIND_SPI, CMD_RDSR, 1'b0, port_held, 8'd0, 16'd0);
            phase_next = PH_SRCMD;
          end
        end
        PH_SRCMD: begin
          g = put(g, KIND_SPI, BYTE_DUMMY, 1'b1, port_held, 8'd0, 16'd0);
          phase_next = PH_SRDATA;
        end
        PH_SRDATA: begin
          if (in_item.data_byte[0]) begin
            g = put(g, KIND_SPI, CMD_RDSR, 1'b0, port_held, 8'd0, 16'd0);
            phase_next = PH_SRCMD;
          end else begin
            // Flash idle: continue the command.
            priority case (active_command)
              OP_WRITE: begin
                if (bytes_left != 24'd0) begin
                  page_room_next = (bytes_left < 24'(PAGE_BYTES)) ? ROOM_W'(bytes_left)
                                                                   : ROOM_W'(PAGE_BYTES);
                  g = put(g, KIND_SPI, CMD_WREN, 1'b1, port_held, 8'd0, 16'd0);
                  phase_next = PH_WEN;
                end else begin
                  g = put(g, KIND_DONE, 8'd0, 1'b0, port_held, 8'd0, 16'd0);
                  phase_next = PH_IDLE;
                end
              end
              OP_ERASE: begin
                if (frame_index == 2'd0) begin
                  g = put(g, KIND_SPI, CMD_SE, 1'b0, port_held, 8'd0, 16'd0);
                  phase_next = PH_CMD;
                end else begin
                  cursor_address_next = cursor_address + 24'(SECTOR_BYTES);
                  sectors_left_next = sect_dec;
                  if (sect_dec != '0) begin
                    g = put(g, KIND_SPI, CMD_WREN, 1'b1, port_held, 8'd0, 16'd0);
                    phase_next = PH_WEN;
                  end else begin
                    g = put(g, KIND_DONE, 8'd0, 1'b0, port_held, 8'd0, 16'd0);
                    phase_next = PH_IDLE;
                  end
                end
              end
              OP_CHIP: begin
                if (frame_index == 2'd0) begin
                  g = put(g, KIND_SPI, CMD_CE, 1'b1, port_held, 8'd0, 16'd0);
                  phase_next = PH_CHIP;
                end else begin
                  g = put(g, KIND_DONE, 8'd0, 1'b0, port_held, 8'd0, 16'd0);
                  phase_next = PH_IDLE;
                end
              end
              default: begin
                g = put(g, KIND_DONE, 8'd0, 1'b0, port_held, 8'd0, 16'd0);
                phase_next = PH_IDLE;
              end
            endcase
          end
        end
        PH_CHIP: begin
          frame_index_next = 2'd1;
          g = put(g, KIND_SPI, CMD_RDSR, 1'b0, port_held, 8'd0, 16'd0);
          phase_next = PH_SRCMD;
        end
        PH_IDHI: begin
          id_accumulator_next = {in_item.data_byte, 8'd0};
          g = put(g, KIND_SPI, BYTE_DUMMY, 1'b1, port_held, 8'd0, 16'd0);
          phase_next = PH_IDLO;
        end
        PH_IDLO: begin
          id_accumulator_next = {id_accumulator[15:8], in_item.data_byte};
          g = put(g, KIND_ID, 8'd0, 1'b0, port_held, 8'd0,
                  {id_accumulator[15:8], in_item.data_byte});
          g = put(g, KIND_DONE, 8'd0, 1'b0, port_held, 8'd0, 16'd0);
          phase_next = PH_IDLE;
        end
        default: ;
      endcase
    end
    // Mark the last result of the group.
    unique case (g.count)
      2'd1:    g.r0.last = 1'b1;
      2'd2:    g.r1.last = 1'b1;
      2'd3:    g.r2.last = 1'b1;
      default: ;
    endcase
  end

  // Sequencer state and the registered result group.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      active_command <= '0;
      cursor_address <= '0;
      bytes_left <= '0;
      page_room <= '0;
      frame_index <= '0;
      sectors_left <= '0;
      id_accumulator <= '0;
      port_held <= '0;
      grp_valid <= 1'b0;
    end else begin
      if (grp_valid && grp_ready) grp_valid <= 1'b0;
      if (fire) begin
        phase <= phase_next;
        active_command <= active_command_next;
        cursor_address <= cursor_address_next;
        bytes_left <= bytes_left_next;
        page_room <= page_room_next;
        frame_index <= frame_index_next;
        sectors_left <= sectors_left_next;
        id_accumulator <= id_accumulator_next;
        port_held <= port_held_next;
        grp_valid <= (g.count != 2'd0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) grp <= g;
  end

endmodule
`default_nettype wire

// ===== rtl/core/snfs_back.sv =====
// Back part: holds a short queue of result groups and emits their results
// one item per cycle while out_ready is high. Depends on snfs_pkg.
`default_nettype none
module snfs_back (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 grp_valid,
  output logic                      grp_ready,
  input  wire snfs_pkg::res_group_t grp,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output snfs_pkg::out_item_t       out_item
);
  import snfs_pkg::*;

  // Two-entry group queue, addressed by one-bit pointers.
  res_group_t q [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] fill;
  logic [1:0] sel;
  logic       push, pop_item, pop_grp;
  res_group_t head;

  assign head      = q[rd_ptr];
  assign grp_ready = (fill != 2'd2);
  assign push      = grp_valid && grp_ready;
  assign out_valid = (fill != 2'd0);
  assign pop_item  = out_valid && out_ready;
  assign pop_grp   = pop_item && (sel == head.count - 2'd1);

  // Pick the current result of the head group.
  always_comb begin
    unique case (sel)
      2'd0:    out_item = head.r0;
      2'd1:    out_item = head.r1;
      default: out_item = head.r2;
    endcase
  end

  // Queue pointers, fill count and position within the head group.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill <= 2'd0;
      sel <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop_grp) begin
        rd_ptr <= ~rd_ptr;
        sel <= 2'd0;
      end else if (pop_item) begin
        sel <= sel + 2'd1;
      end
      fill <= fill + {1'b0, push} - {1'b0, pop_grp};
    end
  end

  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= grp;
  end

endmodule
`default_nettype wire

// ===== rtl/core/spi_nor_flash_sequencer_unit.sv =====
// Top level of the SPI NOR flash sequencer: sequencer front, result queue
// back. Depends on snfs_pkg, snfs_if, snfs_front and snfs_back.
`default_nettype none
// Each input item is a start command, a write-data byte or the flash's reply
// to the last byte sent; the block answers with up to three result items
// (bytes to send with frame ends, read data, the ID, done), last marking the
// final one. The sequencer accepts one item per cycle; results leave one
// per cycle, while out_ready is high, via a two-group queue; an item with
// several results emits them in turn; input stalls only on a full queue.
module spi_nor_flash_sequencer_unit (
  input  wire logic clk,
  input  wire logic rst,
  snfs_in_if.sink   in_ch,
  snfs_out_if.source out_ch
);
  import snfs_pkg::*;

  logic       grp_valid, grp_ready;
  res_group_t grp;

  snfs_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_item(in_ch.payload),
    .grp_valid(grp_valid), .grp_ready(grp_ready), .grp(grp)
  );

  snfs_back u_back (
    .clk(clk), .rst(rst),
    .grp_valid(grp_valid), .grp_ready(grp_ready), .grp(grp),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_item(out_ch.payload)
  );

endmodule
`default_nettype wire
